>>> hdl/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared widths and the command / status bundles between the polygon
// perimeter-area controller and its datapath.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // fixed result and accumulator widths
  localparam int PERIM_W    = 35;
  localparam int AREA_W     = 42;
  localparam int SHOE_W     = 44;
  localparam int VCNT_W     = 11;
  localparam int VCNT_LIMIT = 2047;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // capture the accepted vertex
    logic start_poly;  // vertex opens a new polygon
    logic close_sel;   // edge runs from current vertex back to the first one
    logic mul_dx;      // multiplier: dx * dx
    logic mul_dy;      // multiplier: dy * dy
    logic mul_area;    // multiplier: shoelace term, start the root
    logic root_step;   // one square root iteration
    logic edge_done;   // add length and shoelace term to the sums
    logic adv_vertex;  // current vertex becomes previous, count it
    logic emit;        // load result register, clear the sums
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic count_zero;  // no vertex of the current polygon seen yet
    logic root_last;   // the running root iteration is the final one
    logic out_busy;    // result register holds an untaken result
    logic last_flag;   // captured vertex carries the last flag
  } dp_stat_t;

endpackage

>>> hdl/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer: per edge three multiplier passes, the square root iterations
// and one accumulate step; a closing edge and the result hand-off at the end.
// ----------------------------------------------------------------------------
module ppa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  ppa_pkg::dp_stat_t stat,
  output ppa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MDX  = 7'b0000010,
    S_MDY  = 7'b0000100,
    S_MAR  = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   close_r, close_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    close_nxt     = close_r;
    cmd           = '0;
    cmd.close_sel = close_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (stat.count_zero) begin
            cmd.start_poly = 1'b1;
            if (in_last) begin
              close_nxt = 1'b1;
              state_nxt = S_MDX;
            end
          end else begin
            state_nxt = S_MDX;
          end
        end
      end
      S_MDX: begin
        cmd.mul_dx = 1'b1;
        state_nxt  = S_MDY;
      end
      S_MDY: begin
        cmd.mul_dy = 1'b1;
        state_nxt  = S_MAR;
      end
      S_MAR: begin
        cmd.mul_area = 1'b1;
        state_nxt    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.edge_done = 1'b1;
        if (!close_r) begin
          cmd.adv_vertex = 1'b1;
          if (stat.last_flag) begin
            close_nxt = 1'b1;
            state_nxt = S_MDX;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          close_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        close_nxt = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      close_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      close_r <= close_nxt;
    end
  end

endmodule

>>> hdl/ppa_datapath.sv
// ----------------------------------------------------------------------------
// ppa_datapath
// Vertex registers, one shared signed multiplier, a restoring square root
// (one result bit per cycle), saturating sums and the result register.
// ----------------------------------------------------------------------------
module ppa_datapath #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_CAP   = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ppa_pkg::dp_cmd_t                    cmd,
  output ppa_pkg::dp_stat_t                   stat,
  input  logic signed [COORD_WIDTH-1:0]       in_x,
  input  logic signed [COORD_WIDTH-1:0]       in_y,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ppa_pkg::PERIM_W-1:0]         out_perimeter,
  output logic [ppa_pkg::AREA_W-1:0]          out_double_area,
  output logic [ppa_pkg::VCNT_W-1:0]          out_vertex_total
);

  localparam int CW    = COORD_WIDTH;
  localparam int OP_W  = CW + 1;
  localparam int PR_W  = 2 * OP_W;
  localparam int RT_W  = CW + 1 + FRAC_BITS;
  localparam int NI    = RT_W;
  localparam int IT_W  = (NI > 1) ? $clog2(NI) : 1;
  localparam int REM_W = RT_W + 2;
  localparam int PE_W  = ppa_pkg::PERIM_W;
  localparam int PS_W  = ((PE_W > RT_W) ? PE_W : RT_W) + 1;
  localparam int SH_W  = ppa_pkg::SHOE_W;
  localparam int SA_W  = ((SH_W > PR_W) ? SH_W : PR_W) + 1;
  localparam int AR_W  = ppa_pkg::AREA_W;
  localparam int VC_W  = ppa_pkg::VCNT_W;
  localparam logic [VC_W-1:0] CAP_C = VC_W'(COUNT_CAP);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(NI - 1);

  // vertex registers
  logic signed [CW-1:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 last_r;

  // arithmetic registers
  logic signed [PR_W-1:0] prod_r;
  logic [PR_W-1:0]        sqa_r;
  logic [PR_W-1:0]        rad_r;
  logic [RT_W-1:0]        root_r;
  logic [REM_W-1:0]       rem_r;
  logic [IT_W-1:0]        iter_r;
  logic [PE_W-1:0]        perim_r;
  logic signed [SH_W-1:0] shoe_r;
  logic [VC_W-1:0]        vcnt_r;

  // result register
  logic              out_valid_r;
  logic [PE_W-1:0]   res_perim_r;
  logic [AR_W-1:0]   res_area_r;
  logic [VC_W-1:0]   res_vcnt_r;

  // edge endpoints
  logic signed [CW-1:0]   xa, ya, xb, yb;
  logic signed [OP_W-1:0] dx, dy, sx;
  logic signed [OP_W-1:0] mul_a, mul_b;
  logic signed [PR_W-1:0] product;

  assign xa = cmd.close_sel ? cur_x_r   : prev_x_r;
  assign ya = cmd.close_sel ? cur_y_r   : prev_y_r;
  assign xb = cmd.close_sel ? first_x_r : cur_x_r;
  assign yb = cmd.close_sel ? first_y_r : cur_y_r;

  assign dx = {xb[CW-1], xb} - {xa[CW-1], xa};
  assign dy = {ya[CW-1], ya} - {yb[CW-1], yb};
  assign sx = {xa[CW-1], xa} + {xb[CW-1], xb};

  // shared multiplier operand select
  always_comb begin
    mul_a = dx;
    mul_b = dx;
    if (cmd.mul_dy) begin
      mul_a = dy;
      mul_b = dy;
    end else if (cmd.mul_area) begin
      mul_a = sx;
      mul_b = dy;
    end
  end

  assign product = mul_a * mul_b;

  // one square root iteration
  logic [1:0]       pair;
  logic [REM_W+1:0] rem_sh, trial;
  logic [REM_W-1:0] rem_step;
  logic [RT_W-1:0]  root_step;

  always_comb begin
    pair   = rad_r[PR_W-1 -: 2];
    rem_sh = {rem_r, pair};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_step  = REM_W'(rem_sh - trial);
      root_step = {root_r[RT_W-2:0], 1'b1};
    end else begin
      rem_step  = REM_W'(rem_sh);
      root_step = {root_r[RT_W-2:0], 1'b0};
    end
  end

  // saturating perimeter sum
  logic [PS_W-1:0] perim_sum;
  logic [PE_W-1:0] perim_nxt;

  always_comb begin
    perim_sum = PS_W'(perim_r) + PS_W'(root_r);
    if (perim_sum[PS_W-1:PE_W] != '0) begin
      perim_nxt = {PE_W{1'b1}};
    end else begin
      perim_nxt = perim_sum[PE_W-1:0];
    end
  end

  // saturating shoelace sum
  localparam logic signed [SA_W-1:0] SHOE_HI = SA_W'($signed({1'b0, {(SH_W-1){1'b1}}}));
  localparam logic signed [SA_W-1:0] SHOE_LO = SA_W'($signed({1'b1, {(SH_W-1){1'b0}}}));
  logic signed [SA_W-1:0] shoe_sum;
  logic signed [SH_W-1:0] shoe_nxt;

  always_comb begin
    shoe_sum = {{(SA_W-SH_W){shoe_r[SH_W-1]}}, shoe_r}
             + {{(SA_W-PR_W){prod_r[PR_W-1]}}, prod_r};
    if (shoe_sum > SHOE_HI) begin
      shoe_nxt = SH_W'(SHOE_HI);
    end else if (shoe_sum < SHOE_LO) begin
      shoe_nxt = SH_W'(SHOE_LO);
    end else begin
      shoe_nxt = shoe_sum[SH_W-1:0];
    end
  end

  // absolute area, saturating
  logic [SH_W-1:0] area_abs;
  logic [AR_W-1:0] area_sat;

  always_comb begin
    area_abs = shoe_r[SH_W-1] ? (~shoe_r + 1'b1) : shoe_r;
    if (area_abs[SH_W-1:AR_W] != '0) begin
      area_sat = {AR_W{1'b1}};
    end else begin
      area_sat = area_abs[AR_W-1:0];
    end
  end

  // first and previous vertex registers, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      if (cmd.start_poly) begin
        first_x_r <= in_x;
        first_y_r <= in_y;
        prev_x_r  <= in_x;
        prev_y_r  <= in_y;
      end else if (cmd.adv_vertex) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
    end
  end

  // captured vertex
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_x_r <= in_x;
      cur_y_r <= in_y;
      last_r  <= in_last;
    end
  end

  // multiplier result and root operand
  always_ff @(posedge clk) begin
    if (cmd.mul_dx || cmd.mul_dy || cmd.mul_area) begin
      prod_r <= product;
    end
    if (cmd.mul_dy) begin
      sqa_r <= prod_r;
    end
    if (cmd.mul_area) begin
      rad_r  <= sqa_r + prod_r;
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[PR_W-3:0], 2'b00};
      rem_r  <= rem_step;
      root_r <= root_step;
      iter_r <= iter_r + 1'b1;
    end
  end

  // sums and vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perim_r <= '0;
      shoe_r  <= '0;
      vcnt_r  <= '0;
    end else if (cmd.emit) begin
      perim_r <= '0;
      shoe_r  <= '0;
      vcnt_r  <= '0;
    end else begin
      if (cmd.edge_done) begin
        perim_r <= perim_nxt;
        shoe_r  <= shoe_nxt;
      end
      if (cmd.start_poly) begin
        vcnt_r <= VC_W'(1);
      end else if (cmd.adv_vertex && (vcnt_r < CAP_C)) begin
        vcnt_r <= vcnt_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_perim_r <= perim_r;
      res_area_r  <= area_sat;
      res_vcnt_r  <= vcnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_perimeter    = res_perim_r;
  assign out_double_area  = res_area_r;
  assign out_vertex_total = res_vcnt_r;

  // status
  assign stat.count_zero = (vcnt_r == '0);
  assign stat.root_last  = (iter_r == IT_LAST);
  assign stat.out_busy   = out_valid_r && !out_ready;
  assign stat.last_flag  = last_r;

endmodule

>>> hdl/polygon_perimeter_area.sv
// ----------------------------------------------------------------------------
// polygon_perimeter_area
// Perimeter and doubled shoelace area of a polygon streamed one vertex per
// transaction; a result transaction follows the flagged last vertex.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   x_coord, y_coord, last_vertex
//   out_     output     out_valid / out_ready perimeter, double_area,
//                                             vertex_total
//
// Each edge takes three multiplier passes (dx^2, dy^2, shoelace term on one
// shared multiplier), COORD_WIDTH+1+FRAC_BITS square root iterations and
// one accumulate step. The first vertex of a polygon is only captured.
// The last vertex adds the closing edge and a step to load the result.
// Reset is synchronous; no clearing pass is needed. A new vertex is taken
// while a result waits; only the next result stalls on out_ready.
// ----------------------------------------------------------------------------
module polygon_perimeter_area #(
  parameter int COORD_WIDTH  = 16,
  parameter int FRAC_BITS    = 8,
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]       in_y_coord,
  input  logic                                in_last_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ppa_pkg::PERIM_W-1:0]         out_perimeter,
  output logic [ppa_pkg::AREA_W-1:0]          out_double_area,
  output logic [ppa_pkg::VCNT_W-1:0]          out_vertex_total
);

  localparam int COUNT_CAP = (MAX_VERTICES < ppa_pkg::VCNT_LIMIT) ?
                             MAX_VERTICES : ppa_pkg::VCNT_LIMIT;

  ppa_pkg::dp_cmd_t  cmd;
  ppa_pkg::dp_stat_t stat;

  // sequencer
  ppa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_vertex),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and storage
  ppa_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_CAP   (COUNT_CAP)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_x             (in_x_coord),
    .in_y             (in_y_coord),
    .in_last          (in_last_vertex),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_perimeter    (out_perimeter),
    .out_double_area  (out_double_area),
    .out_vertex_total (out_vertex_total)
  );

endmodule

>>> hdl/ppa_checker.sv
// ----------------------------------------------------------------------------
// ppa_checker
// Port-level checks of the polygon perimeter-area block, bound to the top.
// ----------------------------------------------------------------------------
module ppa_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [COORD_WIDTH-1:0] in_x_coord,
  input logic signed [COORD_WIDTH-1:0] in_y_coord,
  input logic                          in_last_vertex,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ppa_pkg::PERIM_W-1:0]   out_perimeter,
  input logic [ppa_pkg::AREA_W-1:0]    out_double_area,
  input logic [ppa_pkg::VCNT_W-1:0]    out_vertex_total
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_perimeter)
      && $stable(out_double_area) && $stable(out_vertex_total))
    else $error("result changed while stalled");

  // the last vertex starts the closing edge, so the input stalls
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_vertex |=> !in_ready)
    else $error("input taken right after a last vertex");

  // a result appears only after a busy stretch
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without prior work");

  // every polygon has at least one vertex
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertex_total != '0)
    else $error("result with zero vertices");

endmodule

bind polygon_perimeter_area ppa_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_x_coord       (in_x_coord),
  .in_y_coord       (in_y_coord),
  .in_last_vertex   (in_last_vertex),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_perimeter    (out_perimeter),
  .out_double_area  (out_double_area),
  .out_vertex_total (out_vertex_total)
);
